>>> design/mmb_pkg.sv
`timescale 1ns / 1ps

package mmb_pkg;

	// default store geometry
	localparam int DEF_MESSAGE_SLOTS  = 4;
	localparam int DEF_MESSAGE_LENGTH = 16;

	// request kinds
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_NEXT = 2'd1;
	localparam logic [1:0] KIND_PREV = 2'd2;
	localparam logic [1:0] KIND_LOAD = 2'd3;

	// register file: word index = paddr[4:2]
	localparam int NUM_REGS = 5;
	localparam int PADDR_W  = $clog2(NUM_REGS * 4);
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_MESSAGE_COUNT = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_DOT_LENGTH    = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_DASH_LENGTH   = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_LETTER_GAP    = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_WORD_GAP      = REG_IDX_W'(4);

	localparam logic [2:0] RST_MESSAGE_COUNT = 3'd3;
	localparam logic [3:0] RST_DOT_LENGTH    = 4'd2;
	localparam logic [3:0] RST_DASH_LENGTH   = 4'd4;
	localparam logic [3:0] RST_LETTER_GAP    = 4'd2;
	localparam logic [3:0] RST_WORD_GAP      = 4'd4;

	// ASCII codes used by the player and the default messages
	localparam logic [6:0] CHR_A = 7'h61;
	localparam logic [6:0] CHR_Z = 7'h7A;
	localparam logic [6:0] CHR_O = 7'h6F;
	localparam logic [6:0] CHR_S = 7'h73;
	localparam logic [6:0] CHR_NUL = 7'h00;

	typedef struct packed {
		logic [2:0] message_count;
		logic [3:0] dot_length;
		logic [3:0] dash_length;
		logic [3:0] letter_gap_length;
		logic [3:0] word_gap_length;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] message_number;
		logic [3:0] position;
		logic [6:0] character;
	} req_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_wr;
		logic load;
		logic button;
		logic read;
		logic exec;
		logic put;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
	} stat_t;

	// Morse code: symbol count and dash mask (bit i set = symbol i is a dash)
	typedef struct packed {
		logic [2:0] len;
		logic [3:0] dash;
	} morse_t;

	localparam morse_t MORSE_TAB [26] = '{
		'{3'd2, 4'b0010}, '{3'd4, 4'b0001}, '{3'd4, 4'b0101}, '{3'd3, 4'b0001},
		'{3'd1, 4'b0000}, '{3'd4, 4'b0100}, '{3'd3, 4'b0011}, '{3'd4, 4'b0000},
		'{3'd2, 4'b0000}, '{3'd4, 4'b1110}, '{3'd3, 4'b0101}, '{3'd4, 4'b0010},
		'{3'd2, 4'b0011}, '{3'd2, 4'b0001}, '{3'd3, 4'b0111}, '{3'd4, 4'b0110},
		'{3'd4, 4'b1011}, '{3'd3, 4'b0010}, '{3'd3, 4'b0000}, '{3'd1, 4'b0001},
		'{3'd3, 4'b0100}, '{3'd4, 4'b1000}, '{3'd3, 4'b0110}, '{3'd4, 4'b1001},
		'{3'd4, 4'b1101}, '{3'd4, 4'b0011}
	};

	// p mod c for 3-bit values, c >= 1
	function automatic logic [2:0] mod_small(input logic [2:0] p, input logic [2:0] c);
		logic [2:0] r;
		r = p;
		for (int i = 0; i < 7; i++) begin
			if (r >= c) begin
				r = r - c;
			end
		end
		return r;
	endfunction

	// power-up contents: "ss", "oo", "sos", everything else NUL
	function automatic logic [6:0] default_char(input logic [3:0] slot, input logic [5:0] pos);
		logic [6:0] c;
		c = CHR_NUL;
		case (slot)
			4'd0: if (pos < 6'd2) begin
				c = CHR_S;
			end
			4'd1: if (pos < 6'd2) begin
				c = CHR_O;
			end
			4'd2: begin
				if (pos == 6'd0 || pos == 6'd2) begin
					c = CHR_S;
				end else if (pos == 6'd1) begin
					c = CHR_O;
				end
			end
			default: c = CHR_NUL;
		endcase
		return c;
	endfunction

endpackage

>>> design/mmb_req_if.sv
`timescale 1ns / 1ps

interface mmb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [1:0] message_number;
	logic [3:0] position;
	logic [6:0] character;

	modport source (output valid, output kind, output message_number, output position,
		output character, input ready);
	modport sink (input valid, input kind, input message_number, input position,
		input character, output ready);
endinterface

>>> design/mmb_res_if.sv
`timescale 1ns / 1ps

interface mmb_res_if;
	logic       valid;
	logic       ready;
	logic       red_light;
	logic       green_light;
	logic [1:0] playing_message;
	logic       message_done;

	modport source (output valid, output red_light, output green_light,
		output playing_message, output message_done, input ready);
	modport sink (input valid, input red_light, input green_light,
		input playing_message, input message_done, output ready);
endinterface

>>> design/mmb_regs.sv
`timescale 1ns / 1ps

module mmb_regs import mmb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.message_count     <= RST_MESSAGE_COUNT;
			cfg_q.dot_length        <= RST_DOT_LENGTH;
			cfg_q.dash_length       <= RST_DASH_LENGTH;
			cfg_q.letter_gap_length <= RST_LETTER_GAP;
			cfg_q.word_gap_length   <= RST_WORD_GAP;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MESSAGE_COUNT: cfg_q.message_count     <= pwdata[2:0];
				REG_DOT_LENGTH:    cfg_q.dot_length        <= pwdata[3:0];
				REG_DASH_LENGTH:   cfg_q.dash_length       <= pwdata[3:0];
				REG_LETTER_GAP:    cfg_q.letter_gap_length <= pwdata[3:0];
				REG_WORD_GAP:      cfg_q.word_gap_length   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (reg_idx)
			REG_MESSAGE_COUNT: prdata = {29'd0, cfg_q.message_count};
			REG_DOT_LENGTH:    prdata = {28'd0, cfg_q.dot_length};
			REG_DASH_LENGTH:   prdata = {28'd0, cfg_q.dash_length};
			REG_LETTER_GAP:    prdata = {28'd0, cfg_q.letter_gap_length};
			REG_WORD_GAP:      prdata = {28'd0, cfg_q.word_gap_length};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

>>> design/mmb_ctrl.sv
`timescale 1ns / 1ps

module mmb_ctrl import mmb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_kind,
	output logic       req_ready,
	output logic       res_valid,
	input  logic       res_ready,
	input  stat_t      stat,
	output cmd_t       cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_EXEC  = 3'd3;
	localparam logic [2:0] ST_PUT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       res_valid_q;
	logic       req_acc;

	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign res_valid = res_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_acc) begin
					unique case (req_kind) inside
						KIND_TICK: state_nxt = ST_READ;
						KIND_NEXT, KIND_PREV: begin
							cmd.button = 1'b1;
							state_nxt  = ST_PUT;
						end
						KIND_LOAD: begin
							cmd.load  = 1'b1;
							state_nxt = ST_PUT;
						end
					endcase
				end
			end
			ST_READ: begin
				cmd.read  = 1'b1;
				state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = ST_PUT;
			end
			ST_PUT: begin
				cmd.put = !res_valid_q || res_ready;
				if (cmd.put) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.put) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	// memory data is consumed in the cycle after the read was issued
	a_exec_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |-> $past(state_q) == ST_READ)
		else $error("exec without preceding read");

	// a tick request always starts a memory read
	a_tick_reads: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req_kind == KIND_TICK |=> state_q == ST_READ)
		else $error("tick did not start a read");

	// a new response only appears out of the put state
	a_res_from_put: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_PUT)
		else $error("response raised outside put");

	// clearing pass ends only on its last entry
	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == ST_CLEAR && state_q != ST_CLEAR |-> $past(stat.clear_last))
		else $error("clearing pass cut short");
`endif

endmodule

>>> design/mmb_datapath.sv
`timescale 1ns / 1ps

module mmb_datapath import mmb_pkg::*; #(
	parameter int MESSAGE_SLOTS  = DEF_MESSAGE_SLOTS,
	parameter int MESSAGE_LENGTH = DEF_MESSAGE_LENGTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output stat_t      stat,
	input  cfg_t       cfg,
	input  req_t       req,
	output logic       red_light,
	output logic       green_light,
	output logic [1:0] playing_message,
	output logic       message_done
);

	localparam int DEPTH = MESSAGE_SLOTS * MESSAGE_LENGTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = (MESSAGE_SLOTS > 1) ? $clog2(MESSAGE_SLOTS) : 1;
	localparam int PW    = $clog2(MESSAGE_LENGTH);
	localparam int LW    = $clog2(MESSAGE_LENGTH + 1);

	localparam logic [1:0] LIGHT_OFF   = 2'b00;
	localparam logic [1:0] LIGHT_RED   = 2'b01;
	localparam logic [1:0] LIGHT_GREEN = 2'b10;

	// message store
	logic [6:0]    mem [DEPTH];
	logic [6:0]    rd_q;
	logic          rd_oor_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [6:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic          load_ok;

	// clearing pass
	logic [SW-1:0] clr_slot_q;
	logic [PW-1:0] clr_pos_q;
	logic          clr_pos_last;

	// player state
	logic [2:0]    current_q;
	logic [2:0]    pending_q;
	logic          latched_q;
	logic          ended_q;
	logic [LW-1:0] letter_q;
	logic [2:0]    sym_q;
	logic [4:0]    phase_q;
	logic [1:0]    light_q;
	logic          done_q;

	// tick next-state
	logic [2:0]    cur_n;
	logic [2:0]    pend_n;
	logic          latched_n;
	logic          ended_n;
	logic [LW-1:0] letter_n;
	logic [2:0]    sym_n;
	logic [4:0]    phase_n;
	logic [1:0]    light_n;
	logic          done_n;

	logic [2:0]    msg_cnt;
	logic [6:0]    ch;
	logic          known;
	logic [4:0]    tab_idx;
	morse_t        tab;
	logic [2:0]    code_len;
	logic          is_dash;
	logic [3:0]    limit;

	// response payload
	logic          res_red_q;
	logic          res_green_q;
	logic [1:0]    res_msg_q;
	logic          res_done_q;

	assign clr_pos_last    = (clr_pos_q == PW'(MESSAGE_LENGTH - 1));
	assign stat.clear_last = clr_pos_last && (clr_slot_q == SW'(MESSAGE_SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_slot_q <= '0;
			clr_pos_q  <= '0;
		end else if (cmd.clear_wr) begin
			if (clr_pos_last) begin
				clr_pos_q  <= '0;
				clr_slot_q <= clr_slot_q + SW'(1);
			end else begin
				clr_pos_q <= clr_pos_q + PW'(1);
			end
		end
	end

	assign load_ok = (int'(req.message_number) < MESSAGE_SLOTS) &&
		(int'(req.position) < MESSAGE_LENGTH);

	always_comb begin
		if (cmd.clear_wr) begin
			wr_en   = 1'b1;
			wr_addr = AW'(clr_slot_q) * AW'(MESSAGE_LENGTH) + AW'(clr_pos_q);
			wr_data = default_char(4'(clr_slot_q), 6'(clr_pos_q));
		end else begin
			wr_en   = cmd.load && load_ok;
			wr_addr = AW'(req.message_number) * AW'(MESSAGE_LENGTH) + AW'(req.position);
			wr_data = req.character;
		end
	end

	assign rd_addr = AW'(current_q) * AW'(MESSAGE_LENGTH) + AW'(letter_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.read) begin
			rd_q     <= mem[rd_addr];
			rd_oor_q <= (int'(letter_q) >= MESSAGE_LENGTH);
		end
	end

	// message count clamped to 1..MESSAGE_SLOTS
	always_comb begin
		if (cfg.message_count == 3'd0) begin
			msg_cnt = 3'd1;
		end else if (int'(cfg.message_count) > MESSAGE_SLOTS) begin
			msg_cnt = 3'(MESSAGE_SLOTS);
		end else begin
			msg_cnt = cfg.message_count;
		end
	end

	// symbol decode
	assign ch       = rd_oor_q ? CHR_NUL : rd_q;
	assign known    = (ch >= CHR_A) && (ch <= CHR_Z);
	assign tab_idx  = known ? 5'(ch - CHR_A) : 5'd0;
	assign tab      = MORSE_TAB[tab_idx];
	assign code_len = known ? tab.len : 3'd1;
	assign is_dash  = tab.dash[sym_q[1:0]];
	assign limit    = !known ? cfg.word_gap_length :
		(is_dash ? cfg.dash_length : cfg.dot_length);

	always_comb begin
		cur_n     = current_q;
		pend_n    = pending_q;
		latched_n = latched_q;
		ended_n   = ended_q;
		letter_n  = letter_q;
		sym_n     = sym_q;
		phase_n   = phase_q;
		light_n   = light_q;
		done_n    = 1'b0;
		if (ch != CHR_NUL) begin
			ended_n = 1'b0;
			if (sym_q < code_len) begin
				if (phase_q < {1'b0, limit}) begin
					// last tick of a symbol is dark
					if (known && (phase_q + 5'd1) < {1'b0, limit}) begin
						light_n = is_dash ? LIGHT_GREEN : LIGHT_RED;
					end else begin
						light_n = LIGHT_OFF;
					end
					phase_n = phase_q + 5'd1;
				end else begin
					sym_n   = sym_q + 3'd1;
					phase_n = 5'd0;
				end
			end else if (phase_q <= {1'b0, cfg.letter_gap_length}) begin
				light_n = LIGHT_OFF;
				phase_n = phase_q + 5'd1;
			end else begin
				letter_n = letter_q + LW'(1);
				sym_n    = 3'd0;
				phase_n  = 5'd0;
			end
		end else if (phase_q <= {1'b0, cfg.word_gap_length}) begin
			light_n = LIGHT_OFF;
			phase_n = phase_q + 5'd1;
		end else begin
			done_n   = 1'b1;
			ended_n  = 1'b1;
			phase_n  = 5'd0;
			sym_n    = 3'd0;
			letter_n = '0;
		end
		// switch message only at the end of one
		if (pending_q != current_q && ended_n) begin
			cur_n     = mod_small(pending_q, msg_cnt);
			pend_n    = cur_n;
			ended_n   = 1'b0;
			latched_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q <= 3'd0;
			pending_q <= 3'd0;
			latched_q <= 1'b0;
			ended_q   <= 1'b0;
			letter_q  <= '0;
			sym_q     <= 3'd0;
			phase_q   <= 5'd0;
			light_q   <= LIGHT_OFF;
			done_q    <= 1'b0;
		end else if (cmd.exec) begin
			current_q <= cur_n;
			pending_q <= pend_n;
			latched_q <= latched_n;
			ended_q   <= ended_n;
			letter_q  <= letter_n;
			sym_q     <= sym_n;
			phase_q   <= phase_n;
			light_q   <= light_n;
			done_q    <= done_n;
		end else if (cmd.button) begin
			if (!latched_q) begin
				if (req.kind == KIND_NEXT) begin
					pending_q <= pending_q + 3'd1;
				end else begin
					pending_q <= pending_q + msg_cnt - 3'd1;
				end
				latched_q <= 1'b1;
			end
			done_q <= 1'b0;
		end else if (cmd.load) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			res_red_q   <= light_q[0];
			res_green_q <= light_q[1];
			res_msg_q   <= current_q[1:0];
			res_done_q  <= done_q;
		end
	end

	assign red_light       = res_red_q;
	assign green_light     = res_green_q;
	assign playing_message = res_msg_q;
	assign message_done    = res_done_q;

endmodule

>>> design/morse_message_beacon.sv
// Morse message beacon. Plays one of several stored messages as Morse code on a red
// light (dots) and a green light (dashes), one phase per tick request; next/previous
// requests latch one message change that takes effect when the current message ends,
// and load requests overwrite single characters of the store. Every request returns
// exactly one response with the light state, the message being played and a flag for
// the tick that closed a message. A tick request passes idle, store read, update and
// response write before another request is taken, as the single message memory is read
// through a register; next, previous and load go from idle to the response write.
// The response register lets a new request in while the last response still waits.
// After reset the block writes the power-up messages (ss, oo, sos) into the store,
// one entry per cycle, until its MESSAGE_SLOTS*MESSAGE_LENGTH entries (64 by default)
// are in; request ready is held low meanwhile, the APB registers writable throughout.
`timescale 1ns / 1ps

module morse_message_beacon import mmb_pkg::*; #(
	parameter int MESSAGE_SLOTS  = DEF_MESSAGE_SLOTS,
	parameter int MESSAGE_LENGTH = DEF_MESSAGE_LENGTH
) (
	input  logic               clk,
	input  logic               arst_n,
	mmb_req_if.sink            req,
	mmb_res_if.source          res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;
	req_t  req_data;

	// flatten the request payload for the datapath
	assign req_data.kind           = req.kind;
	assign req_data.message_number = req.message_number;
	assign req_data.position       = req.position;
	assign req_data.character      = req.character;

	// timing and message-count registers
	mmb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencing: clearing pass, request accept, read/update, response handoff
	mmb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// message store, player state and response register
	mmb_datapath #(
		.MESSAGE_SLOTS  (MESSAGE_SLOTS),
		.MESSAGE_LENGTH (MESSAGE_LENGTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg             (cfg),
		.req             (req_data),
		.red_light       (res.red_light),
		.green_light     (res.green_light),
		.playing_message (res.playing_message),
		.message_done    (res.message_done)
	);

endmodule
